@@ rtl/bpnhs_pkg.sv @@
// bpnhs_pkg: types, constants and codes for the next-hop selector.
// No dependencies.
package bpnhs_pkg;

   localparam int TABLE_ENTRIES_DEF = 16;
   localparam logic [7:0] MAX_LIFETIME_RST = 8'd10;
   localparam logic [7:0] LINK_LOSS_SCALE_RST = 8'd1;

   localparam logic [1:0] MODE_ROUTE  = 2'd0;
   localparam logic [1:0] MODE_LINK   = 2'd1;
   localparam logic [1:0] MODE_UPDATE = 2'd2;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_NONE    = 2'd1;
   localparam logic [1:0] ST_FULL    = 2'd2;
   localparam logic [1:0] ST_UNKNOWN = 2'd3;

   localparam logic [0:0] CSR_MAX_LIFETIME    = 1'd0;
   localparam logic [0:0] CSR_LINK_LOSS_SCALE = 1'd1;

   localparam logic [9:0] ETX_FAIL = 10'd1000;

   typedef struct packed {
      logic [1:0]  mode;
      logic [15:0] neighbor_addr;
      logic        link_success;
      logic [15:0] queue_length;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] next_hop_addr;
      logic [15:0] next_hop_queue;
      logic [9:0]  prev_link_etx;
   } rsp_type;

   // request to the shared divider
   typedef struct packed {
      logic        start;
      logic [47:0] num;
      logic [31:0] den;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [47:0] quo;
   } div_rsp_type;

endpackage

@@ rtl/backpressure_next_hop_selector.sv @@
// backpressure_next_hop_selector: neighbour table and next-hop choice.
// Depends on bpnhs_pkg and bpnhs_div.
//
//  channel | ports                         | flow
//  req     | start, busy, req_payload      | in, taken on start & !busy
//  rsp     | rsp_valid, rsp_payload        | out, one-cycle strobe
//  csr     | csr_we, csr_index, csr_wdata  | in, taken on csr_we
//
// Queue update and link report go through a lookup state and a result state. A
// route request visits each slot in turn; a live entry takes two passes through
// the shared 48-bit divider for ETX and 10000/ETX, plus lookup, weight multiplies
// and the /100 scaling, an empty or expired slot is skipped, and an entry can drop
// out early. Synchronous reset clears valid bits and control;
// tables are unset. Results cannot be stalled.
module backpressure_next_hop_selector #(
   parameter int TABLE_ENTRIES = bpnhs_pkg::TABLE_ENTRIES_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  bpnhs_pkg::req_type   req_payload,
   output logic                 rsp_valid,
   output bpnhs_pkg::rsp_type   rsp_payload,
   input  logic                 csr_we,
   input  logic [0:0]           csr_index,
   input  logic [7:0]           csr_wdata
);

   localparam int IW = $clog2(TABLE_ENTRIES);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_FIND  = 4'd1;
   localparam logic [3:0] S_ENT   = 4'd2;
   localparam logic [3:0] S_DIV1  = 4'd3;
   localparam logic [3:0] S_W1    = 4'd4;
   localparam logic [3:0] S_DIV2  = 4'd5;
   localparam logic [3:0] S_W2    = 4'd6;
   localparam logic [3:0] S_MUL1  = 4'd7;
   localparam logic [3:0] S_MUL2  = 4'd8;
   localparam logic [3:0] S_MUL3  = 4'd9;
   localparam logic [3:0] S_NEXT  = 4'd10;
   localparam logic [3:0] S_DONE  = 4'd11;
   localparam logic [3:0] S_SCALE = 4'd12;
   localparam logic [3:0] S_BEST  = 4'd13;

   // reciprocal of 100, exact for any 32-bit dividend with a shift of 37
   localparam logic [63:0] RECIP_100 = 64'd1374389535;

   logic [TABLE_ENTRIES-1:0] valid_ff, valid_in;
   logic [15:0] addr_q  [TABLE_ENTRIES];
   logic [15:0] queue_q [TABLE_ENTRIES];
   logic [7:0]  life_q  [TABLE_ENTRIES];
   logic [31:0] gg_q [TABLE_ENTRIES];
   logic [31:0] gb_q [TABLE_ENTRIES];
   logic [31:0] bg_q [TABLE_ENTRIES];
   logic [31:0] bb_q [TABLE_ENTRIES];
   logic        last_q [TABLE_ENTRIES];

   logic [7:0] max_life_ff, scale_ff;
   logic [3:0] state_ff, state_in;
   bpnhs_pkg::req_type req_ff, req_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic        any_ff, any_in, have_ff, have_in;
   logic signed [33:0] best_w_ff, best_w_in;
   logic [IW-1:0] best_ff, best_in;
   logic [15:0] etx_ff, etx_in, phi_ff, phi_in;
   logic signed [16:0] diff_ff, diff_in;
   logic signed [33:0] prod_ff, prod_in;
   logic signed [15:0] f_ff, f_in;
   logic signed [34:0] w0_ff, w0_in;
   logic signed [31:0] wm_ff, wm_in;
   logic signed [33:0] w_ff, w_in;
   logic        rsp_valid_ff, rsp_valid_in;
   bpnhs_pkg::rsp_type rsp_ff, rsp_in;

   bpnhs_pkg::div_req_type dreq;
   bpnhs_pkg::div_rsp_type drsp;

   // lookup and free slot search
   logic          hit;
   logic [IW-1:0] hit_idx;
   logic          free;
   logic [IW-1:0] free_idx;

   always_comb begin
      hit = 1'b0;
      hit_idx = '0;
      free = 1'b0;
      free_idx = '0;
      for (int k = TABLE_ENTRIES - 1; k >= 0; k--) begin
         if (valid_ff[k] && addr_q[k] == req_ff.neighbor_addr) begin
            hit = 1'b1;
            hit_idx = IW'(k);
         end
         if (!valid_ff[k]) begin
            free = 1'b1;
            free_idx = IW'(k);
         end
      end
   end

   logic [31:0] hcnt, mcnt;
   logic [32:0] hsum;
   logic [47:0] num48;
   logic [15:0] dq;
   logic signed [15:0] w0lo;
   logic [15:0] p1;
   logic [31:0] wabs;
   logic [63:0] wrec;
   logic [26:0] wq;

   bpnhs_div u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   always_comb begin
      state_in = state_ff;
      req_in = req_ff;
      idx_in = idx_ff;
      valid_in = valid_ff;
      any_in = any_ff;
      have_in = have_ff;
      best_w_in = best_w_ff;
      best_in = best_ff;
      etx_in = etx_ff;
      phi_in = phi_ff;
      diff_in = diff_ff;
      prod_in = prod_ff;
      f_in = f_ff;
      w0_in = w0_ff;
      wm_in = wm_ff;
      w_in = w_ff;
      rsp_valid_in = 1'b0;
      rsp_in = rsp_ff;
      dreq = '0;
      hcnt = last_q[idx_ff] ? gg_q[idx_ff] : bg_q[idx_ff];
      mcnt = last_q[idx_ff] ? gb_q[idx_ff] : bb_q[idx_ff];
      hsum = {1'b0, hcnt} + {1'b0, mcnt};
      num48 = 48'(hsum) * 48'(scale_ff);
      dq = (drsp.quo > 48'd65535) ? 16'hFFFF : drsp.quo[15:0];
      w0lo = w0_ff[15:0];
      p1 = prod_ff[15:0];
      // magnitude of the product, divided by 100 and truncated toward zero
      wabs = wm_ff[31] ? (~wm_ff + 32'd1) : wm_ff;
      wrec = 64'(wabs) * RECIP_100;
      wq = wrec[63:37];
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in = req_payload;
               idx_in = '0;
               any_in = 1'b0;
               have_in = 1'b0;
               best_w_in = -34'sd1;
               rsp_in = '0;
               state_in = (req_payload.mode == bpnhs_pkg::MODE_ROUTE) ? S_ENT : S_FIND;
            end
         end
         S_FIND: begin
            if (req_ff.mode == bpnhs_pkg::MODE_LINK) begin
               if (!hit) rsp_in.status = bpnhs_pkg::ST_UNKNOWN;
            end else if (req_ff.mode == bpnhs_pkg::MODE_UPDATE) begin
               if (!hit && !free) rsp_in.status = bpnhs_pkg::ST_FULL;
               else if (!hit) valid_in[free_idx] = 1'b1;
            end
            state_in = S_DONE;
         end
         S_ENT: begin
            if (valid_ff[idx_ff]) begin
               any_in = 1'b1;
               if (life_q[idx_ff] != 8'd0) begin
                  diff_in = 17'(signed'(req_ff.queue_length - queue_q[idx_ff]));
                  if (hcnt == 32'd0) begin
                     etx_in = 16'hFFFF;
                     state_in = S_W1;
                  end else begin
                     // numerator x100 folded in: scale*(h+m)*100
                     dreq.start = 1'b1;
                     dreq.num = (num48 << 6) + (num48 << 5) + (num48 << 2);
                     dreq.den = hcnt;
                     state_in = S_DIV1;
                  end
               end else begin
                  state_in = S_NEXT;
               end
            end else begin
               state_in = S_NEXT;
            end
         end
         S_DIV1: begin
            if (drsp.done) begin
               etx_in = dq;
               state_in = S_W1;
            end
         end
         S_W1: begin
            if (etx_ff == 16'd0 || diff_ff[15:0] == 16'd0 || diff_ff[15]) begin
               state_in = S_NEXT;
            end else begin
               dreq.start = 1'b1;
               dreq.num = 48'd10000;
               dreq.den = 32'(etx_ff);
               state_in = S_DIV2;
            end
         end
         S_DIV2: begin
            if (drsp.done) begin
               phi_in = drsp.quo[15:0];
               state_in = S_W2;
            end
         end
         S_W2: begin
            prod_in = 34'(signed'({1'b0, phi_ff})) * 34'(signed'({1'b0, diff_ff[14:0]}));
            state_in = S_MUL1;
         end
         S_MUL1: begin
            f_in = (p1 < 16'd100) ? 16'sd100 : signed'(p1);
            state_in = S_MUL2;
         end
         S_MUL2: begin
            w0_in = 35'(prod_ff <<< 1) - 35'(f_ff);
            state_in = S_MUL3;
         end
         S_MUL3: begin
            if (w0lo <= 16'sd0 || f_ff == 16'sd0) begin
               state_in = S_NEXT;
            end else begin
               wm_in = 32'(w0_ff * 35'(f_ff));
               state_in = S_SCALE;
            end
         end
         S_SCALE: begin
            w_in = wm_ff[31] ? -34'(wq) : 34'(wq);
            state_in = S_BEST;
         end
         S_BEST: begin
            // life decrement happens alongside in the register block
            if (w_ff > best_w_ff) begin
               best_w_in = w_ff;
               best_in = idx_ff;
               have_in = 1'b1;
            end
            state_in = S_NEXT;
         end
         S_NEXT: begin
            if (idx_ff == IW'(TABLE_ENTRIES - 1)) begin
               if (!any_ff) begin
                  rsp_in.status = bpnhs_pkg::ST_NONE;
               end else if (have_ff && best_w_ff >= 34'sd100) begin
                  rsp_in.next_hop_addr = addr_q[best_ff];
                  rsp_in.next_hop_queue = queue_q[best_ff];
               end else begin
                  rsp_in.status = bpnhs_pkg::ST_NONE;
                  rsp_in.prev_link_etx = bpnhs_pkg::ETX_FAIL;
               end
               state_in = S_DONE;
            end else begin
               idx_in = idx_ff + IW'(1);
               state_in = S_ENT;
            end
         end
         S_DONE: begin
            rsp_valid_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_FIND && req_ff.mode == bpnhs_pkg::MODE_UPDATE) begin
         if (hit) begin
            queue_q[hit_idx] <= req_ff.queue_length;
            life_q[hit_idx]  <= max_life_ff;
         end else if (free) begin
            addr_q[free_idx]  <= req_ff.neighbor_addr;
            queue_q[free_idx] <= req_ff.queue_length;
            life_q[free_idx]  <= max_life_ff;
            gg_q[free_idx] <= 32'd1;
            gb_q[free_idx] <= 32'd0;
            bg_q[free_idx] <= 32'd1;
            bb_q[free_idx] <= 32'd0;
            last_q[free_idx] <= 1'b1;
         end
      end
      if (state_ff == S_FIND && req_ff.mode == bpnhs_pkg::MODE_LINK && hit) begin
         if (req_ff.link_success) begin
            if (last_q[hit_idx]) begin
               if (gg_q[hit_idx] != '1) gg_q[hit_idx] <= gg_q[hit_idx] + 32'd1;
            end else begin
               if (bg_q[hit_idx] != '1) bg_q[hit_idx] <= bg_q[hit_idx] + 32'd1;
            end
         end else begin
            if (last_q[hit_idx]) begin
               if (gb_q[hit_idx] != '1) gb_q[hit_idx] <= gb_q[hit_idx] + 32'd1;
            end else begin
               if (bb_q[hit_idx] != '1) bb_q[hit_idx] <= bb_q[hit_idx] + 32'd1;
            end
         end
         last_q[hit_idx] <= req_ff.link_success;
      end
      if (state_ff == S_BEST) life_q[idx_ff] <= life_q[idx_ff] - 8'd1;
      req_ff <= req_in;
      idx_ff <= idx_in;
      best_w_ff <= best_w_in;
      best_ff <= best_in;
      etx_ff <= etx_in;
      phi_ff <= phi_in;
      diff_ff <= diff_in;
      prod_ff <= prod_in;
      f_ff <= f_in;
      w0_ff <= w0_in;
      wm_ff <= wm_in;
      w_ff <= w_in;
      rsp_ff <= rsp_in;
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= '0;
         any_ff <= 1'b0;
         have_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         max_life_ff <= bpnhs_pkg::MAX_LIFETIME_RST;
         scale_ff <= bpnhs_pkg::LINK_LOSS_SCALE_RST;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         any_ff <= any_in;
         have_ff <= have_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we && csr_index == bpnhs_pkg::CSR_MAX_LIFETIME) max_life_ff <= csr_wdata;
         if (csr_we && csr_index == bpnhs_pkg::CSR_LINK_LOSS_SCALE) scale_ff <= csr_wdata;
      end
   end

   assign busy = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

@@ rtl/bpnhs_div.sv @@
// bpnhs_div: radix-2 restoring divider, one quotient bit per cycle.
// Depends on bpnhs_pkg.
module bpnhs_div (
   input  logic                  clock,
   input  logic                  reset,
   input  bpnhs_pkg::div_req_type req,
   output bpnhs_pkg::div_rsp_type rsp
);

   logic [47:0] quo_ff, quo_in;
   logic [32:0] rem_ff, rem_in;
   logic [31:0] den_ff, den_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [32:0] trial;
   logic [33:0] diffv;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[31:0], quo_ff[47]};
      diffv   = {1'b0, trial} - {2'b00, den_ff};
      if (req.start) begin
         quo_in  = req.num;
         rem_in  = '0;
         den_in  = req.den;
         cnt_in  = 6'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diffv[33]) begin
            rem_in = diffv[32:0];
            quo_in = {quo_ff[46:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[46:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd47) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign rsp.done = done_ff;
   assign rsp.quo  = quo_ff;

endmodule

@@ rtl/bpnhs_checker.sv @@
// bpnhs_checker: port-level assertions for the next-hop selector, with bind.
// Depends on bpnhs_pkg.
module bpnhs_checker (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               rsp_valid,
   input bpnhs_pkg::rsp_type rsp_payload
);

   // a transfer in makes the block busy next cycle
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("no busy after start");

   // a result is a single strobe
   a_one_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("double result");

   // result ends the busy period
   a_idle_after: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("busy with result");

   // fail code only with status none
   a_fail_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.prev_link_etx != 10'd0 |->
         rsp_payload.status == bpnhs_pkg::ST_NONE) else $error("bad etx code");

endmodule

bind backpressure_next_hop_selector bpnhs_checker u_chk (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_payload(rsp_payload)
);
